[src/pwl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared types and constants for the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pwl_pkg;

    localparam int DEFAULT_MAX_POINTS = 16;

    // item opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam logic CFG_EXTRAPOLATE = 1'b0;
    localparam logic CFG_POINTS      = 1'b1;

    localparam int CFG_DATA_W = 5;

    // configuration reset values
    localparam logic                  EXTRAPOLATE_RESET = 1'b1;
    localparam logic [CFG_DATA_W-1:0] POINTS_RESET      = 5'd2;

    localparam logic signed [34:0] RES_MAX = 35'sd2147483647;
    localparam logic signed [34:0] RES_MIN = -35'sd2147483648;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_FCMP,
        S_SCAN,
        S_SCMP,
        S_RDL,
        S_RDR,
        S_PREP,
        S_DIFF,
        S_MUL0,
        S_MUL1,
        S_DCHK,
        S_DIV,
        S_FIN
    } pwl_state_t;

endpackage : pwl_pkg
`default_nettype wire

[src/piecewise_linear_interpolator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table with segment search, slope multiply and restoring divide.
//
//   channel   ports                                          direction
//   -------   ---------------------------------------------  ---------
//   item      start, busy (out), opcode, point_index,        in
//             x_value, y_value
//   result    done, y_result, segment_used,                  out
//             degenerate_segment, saturated
//   config    cfg_write, cfg_index, cfg_data                 in
//
// A load is written to the table in the cycle it is taken; busy stays low.
// A query keeps busy high through a linear scan that compares breakpoints
// one at a time (none when x is at or past the next-to-last breakpoint, at
// most 14 for a full table), a two-pass 33x17 multiply and the 33 steps of
// a one-bit-per-cycle restoring divide; a degenerate segment skips the
// multiply and the divide, and an overflowing quotient skips the divide.
// done pulses in the cycle in which busy falls. The table has one read
// port, read once per step.
// Reset clears the sequencer and configuration; the table is not cleared.
// Results cannot be stalled: each one is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator
    import pwl_pkg::*;
#(
    parameter int MAX_POINTS = DEFAULT_MAX_POINTS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  opcode,
    input  wire logic [3:0]            point_index,
    input  wire logic signed [31:0]    x_value,
    input  wire logic signed [31:0]    y_value,
    output logic                       done,
    output logic signed [31:0]         y_result,
    output logic [3:0]                 segment_used,
    output logic                       degenerate_segment,
    output logic                       saturated,
    input  wire logic                  cfg_write,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

    pwl_state_t state_reg, state_next;

    logic                  extrapolate_reg;
    logic [CFG_DATA_W-1:0] points_reg;

    logic signed [31:0] mem_x [MAX_POINTS];
    logic signed [31:0] mem_y [MAX_POINTS];
    logic signed [31:0] rd_x_reg, rd_y_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;

    logic [IDX_W-1:0]   nm2_reg, nm2_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W:0]     idx_inc;

    logic signed [31:0] xq_reg, xl_reg, xr_reg, yl_reg, yr_reg;
    logic signed [31:0] yl_clamp, yr_clamp;

    logic signed [32:0] dy, dx, dd;
    logic [32:0]        mag_a_reg, mag_b_reg, mag_d_reg;
    logic               neg_reg, degen_reg, ovf_reg;

    logic [16:0]        mul_b;
    logic [49:0]        mul_p;
    logic [65:0]        prod_reg;

    logic [32:0]        r_reg, pl_reg, q_reg;
    logic [5:0]         cnt_reg;
    logic [33:0]        r_shift, r_sub;
    logic               r_fits;

    logic signed [34:0] sum;
    logic               x_ge, x_gt, more_steps, quot_ovf;

    logic               done_reg;
    logic signed [31:0] y_result_reg;
    logic [3:0]         segment_reg;
    logic               degen_out_reg, sat_out_reg;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extrapolate_reg <= EXTRAPOLATE_RESET;
            points_reg      <= POINTS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_EXTRAPOLATE: extrapolate_reg <= cfg_data[0];
                CFG_POINTS:      points_reg      <= cfg_data;
                default:         ;
            endcase
        end
    end

    // last usable left index, with the point count clamped to the table
    always_comb
    begin
        if (points_reg < 5'd2)
            nm2_next = '0;
        else if (32'(points_reg) > MAX_POINTS)
            nm2_next = IDX_W'(MAX_POINTS - 2);
        else
            nm2_next = IDX_W'(points_reg - 5'd2);
    end

    // ------------------------------------------------------------------
    // breakpoint table
    // ------------------------------------------------------------------
    assign wr_en = start && !busy && (opcode == OP_LOAD)
                   && (32'(point_index) < MAX_POINTS);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[IDX_W'(point_index)] <= x_value;
            mem_y[IDX_W'(point_index)] <= y_value;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
    end

    // ------------------------------------------------------------------
    // compares and shared arithmetic
    // ------------------------------------------------------------------
    assign idx_inc    = {1'b0, idx_reg} + (IDX_W + 1)'(1);
    assign x_ge       = xq_reg >= rd_x_reg;
    assign x_gt       = xq_reg > rd_x_reg;
    assign more_steps = idx_inc < {1'b0, nm2_reg};

    // clamp when not extrapolating: rd holds the right end in S_PREP
    assign yr_clamp = (!extrapolate_reg && (xq_reg < xl_reg)) ? yl_reg : rd_y_reg;
    assign yl_clamp = (!extrapolate_reg && (xq_reg > rd_x_reg)) ? yr_clamp : yl_reg;

    assign dy = 33'(yr_reg) - 33'(yl_reg);
    assign dx = 33'(xq_reg) - 33'(xl_reg);
    assign dd = 33'(xr_reg) - 33'(xl_reg);

    assign mul_b = (state_reg == S_MUL0) ? {1'b0, mag_b_reg[15:0]} : mag_b_reg[32:16];
    assign mul_p = mag_a_reg * mul_b;

    // quotient would not fit in 33 bits: result saturates anyway
    assign quot_ovf = prod_reg[65:33] >= mag_d_reg;

    assign r_shift = {r_reg, pl_reg[32]};
    assign r_sub   = r_shift - {1'b0, mag_d_reg};
    assign r_fits  = r_shift >= {1'b0, mag_d_reg};

    assign sum = neg_reg ? (35'(yl_reg) - 35'({2'b00, q_reg}))
                         : (35'(yl_reg) + 35'({2'b00, q_reg}));

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && (opcode == OP_QUERY))
                    state_next = S_FIRST;
            end
            S_FIRST: state_next = S_FCMP;
            S_FCMP:
            begin
                if (x_ge || (nm2_reg == '0))
                    state_next = S_RDL;
                else
                    state_next = S_SCAN;
            end
            S_SCAN: state_next = S_SCMP;
            S_SCMP:
            begin
                if (x_gt && more_steps)
                    state_next = S_SCAN;
                else
                    state_next = S_RDL;
            end
            S_RDL:  state_next = S_RDR;
            S_RDR:  state_next = S_PREP;
            S_PREP: state_next = S_DIFF;
            S_DIFF:
            begin
                if (xr_reg == xl_reg)
                    state_next = S_FIN;
                else
                    state_next = S_MUL0;
            end
            S_MUL0: state_next = S_MUL1;
            S_MUL1: state_next = S_DCHK;
            S_DCHK:
            begin
                if (quot_ovf)
                    state_next = S_FIN;
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = S_FIN;
            end
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy    = (state_reg != S_IDLE);
        rd_addr = idx_reg;
        unique case (state_reg)
            S_FIRST:       rd_addr = nm2_reg;
            S_SCAN, S_RDR: rd_addr = idx_inc[IDX_W-1:0];
            default:       rd_addr = idx_reg;
        endcase
    end

    // segment index and point count are control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            nm2_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start && (opcode == OP_QUERY))
                    begin
                        idx_reg <= '0;
                        nm2_reg <= nm2_next;
                    end
                end
                S_FCMP:
                begin
                    if (x_ge)
                        idx_reg <= nm2_reg;
                    else
                        idx_reg <= '0;
                end
                S_SCMP:
                begin
                    if (x_gt)
                        idx_reg <= idx_inc[IDX_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start && !busy)
                    xq_reg <= x_value;
            end
            S_RDR:
            begin
                xl_reg <= rd_x_reg;
                yl_reg <= rd_y_reg;
            end
            S_PREP:
            begin
                xr_reg <= rd_x_reg;
                yr_reg <= yr_clamp;
                yl_reg <= yl_clamp;
            end
            S_DIFF:
            begin
                mag_a_reg <= dy[32] ? (33'd0 - dy) : dy;
                mag_b_reg <= dx[32] ? (33'd0 - dx) : dx;
                mag_d_reg <= dd[32] ? (33'd0 - dd) : dd;
                neg_reg   <= dy[32] ^ dx[32] ^ dd[32];
                degen_reg <= (xr_reg == xl_reg);
                ovf_reg   <= 1'b0;
            end
            S_MUL0: prod_reg <= {16'd0, mul_p};
            S_MUL1: prod_reg <= prod_reg + {mul_p, 16'd0};
            S_DCHK:
            begin
                ovf_reg <= quot_ovf;
                r_reg   <= prod_reg[65:33];
                pl_reg  <= prod_reg[32:0];
                q_reg   <= '0;
                cnt_reg <= 6'd32;
            end
            S_DIV:
            begin
                // one quotient bit per cycle
                r_reg   <= r_fits ? r_sub[32:0] : r_shift[32:0];
                pl_reg  <= {pl_reg[31:0], 1'b0};
                q_reg   <= {q_reg[31:0], r_fits};
                cnt_reg <= cnt_reg - 6'd1;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // result
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (state_reg == S_FIN);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN)
        begin
            segment_reg   <= 4'(idx_reg);
            degen_out_reg <= degen_reg;
            if (degen_reg)
            begin
                y_result_reg <= yl_reg;
                sat_out_reg  <= 1'b0;
            end
            else if (ovf_reg)
            begin
                y_result_reg <= neg_reg ? RES_MIN[31:0] : RES_MAX[31:0];
                sat_out_reg  <= 1'b1;
            end
            else if (sum > RES_MAX)
            begin
                y_result_reg <= RES_MAX[31:0];
                sat_out_reg  <= 1'b1;
            end
            else if (sum < RES_MIN)
            begin
                y_result_reg <= RES_MIN[31:0];
                sat_out_reg  <= 1'b1;
            end
            else
            begin
                y_result_reg <= sum[31:0];
                sat_out_reg  <= 1'b0;
            end
        end
    end

    assign done               = done_reg;
    assign y_result           = y_result_reg;
    assign segment_used       = segment_reg;
    assign degenerate_segment = degen_out_reg;
    assign saturated          = sat_out_reg;

`ifndef SYNTHESIS
    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_FIN))
        else $error("result strobe without a finished query");

    a_busy_on_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && (opcode == OP_QUERY)))
        else $error("sequencer left idle without a query transfer");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (idx_reg <= nm2_reg))
        else $error("segment index beyond last usable segment");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (r_reg < mag_d_reg))
        else $error("divider remainder not below divisor");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(degenerate_segment && saturated))
        else $error("degenerate result flagged as saturated");
`endif

endmodule : piecewise_linear_interpolator
`default_nettype wire
